@@ design/brm_pkg.sv @@
// Package for the radix-2 Booth multiplier: field widths, digit grouping, pipeline item type.
// No dependencies; every other design file imports it.
package brm_pkg;

   localparam int OPERAND_W     = 32;
   localparam int PRODUCT_W     = 64;
   localparam int COUNT_W       = 6;
   localparam int CFG_W         = 6;
   // Booth digits retired by each accumulation stage
   localparam int GROUP_DIGITS  = 8;
   // multiplier with the implicit zero below bit 0 and zero padding above
   localparam int EXT_W         = OPERAND_W + GROUP_DIGITS + 1;
   localparam logic [CFG_W-1:0] WIDTH_RESET = 6'd32;

   typedef struct packed {
      logic [OPERAND_W-1:0] multiplicand;
      logic [OPERAND_W-1:0] multiplier;
      logic [PRODUCT_W-1:0] product;
      logic [COUNT_W-1:0]   nonzero_digits;
   } brm_item_type;

endpackage

@@ design/brm_if.sv @@
// Channel interfaces of the Booth multiplier: operand request, product response, width write.
// Depends on brm_pkg for the field widths.
interface brm_req_if import brm_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [OPERAND_W-1:0] multiplicand;
   logic [OPERAND_W-1:0] multiplier;

   modport source (output valid, output multiplicand, output multiplier, input ready);
   modport sink   (input valid, input multiplicand, input multiplier, output ready);
endinterface

interface brm_rsp_if import brm_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [PRODUCT_W-1:0] product;
   logic [COUNT_W-1:0]   nonzero_digits;

   modport source (output valid, output product, output nonzero_digits, input ready);
   modport sink   (input valid, input product, input nonzero_digits, output ready);
endinterface

interface brm_csr_if import brm_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [CFG_W-1:0] operand_width;

   modport source (output valid, output operand_width, input ready);
   modport sink   (input valid, input operand_width, output ready);
endinterface

@@ design/brm_booth_stage.sv @@
// One accumulation stage: applies a group of radix-2 Booth digits to the running product.
// Depends on brm_pkg for the item type and group size.
module brm_booth_stage import brm_pkg::*; #(
   parameter int STAGE_IDX = 0
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         up_valid,
   input  brm_item_type up_item,
   output logic         up_ready,
   output logic         dn_valid,
   input  logic         dn_ready,
   output brm_item_type dn_item
);

   localparam int LSB    = GROUP_DIGITS * STAGE_IDX;
   localparam int PART_W = OPERAND_W + GROUP_DIGITS + 2;

   logic                          valid_ff;
   brm_item_type                  item_ff;
   brm_item_type                  item_in;
   logic [EXT_W-1:0]              ext_mult;
   logic [GROUP_DIGITS:0]         window;
   logic signed [GROUP_DIGITS+1:0] group_val;
   logic signed [PART_W-1:0]      partial;
   logic [PRODUCT_W-1:0]          partial_ext;
   logic [3:0]                    digit_cnt;

   // load when empty or when the next stage takes our item
   assign up_ready = !valid_ff || dn_ready;

   // Booth window: bit 0 is the bit below the group, then the group's own bits
   always_comb begin
      ext_mult = {{GROUP_DIGITS{1'b0}}, up_item.multiplier, 1'b0};
      window   = ext_mult[LSB +: GROUP_DIGITS + 1];
   end

   // digit j = m[j-1] - m[j]; the group sums to window_low - window_high
   always_comb begin
      group_val = $signed({2'b00, window[GROUP_DIGITS-1:0]})
                - $signed({2'b00, window[GROUP_DIGITS:1]});
      digit_cnt = '0;
      for (int j = 0; j < GROUP_DIGITS; j++) begin
         digit_cnt = digit_cnt + 4'(window[j] ^ window[j+1]);
      end
   end

   // signed partial product of the group, sign-extended and weighted
   always_comb begin
      partial     = PART_W'($signed({1'b0, up_item.multiplicand})) * PART_W'(group_val);
      partial_ext = PRODUCT_W'(partial) << LSB;
      item_in                = up_item;
      item_in.product        = up_item.product + partial_ext;
      item_in.nonzero_digits = up_item.nonzero_digits + COUNT_W'(digit_cnt);
   end

   // hold valid across stalls
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (up_ready) begin
         valid_ff <= up_valid;
      end
   end

   // advance the payload
   always_ff @(posedge clock) begin
      if (up_ready && up_valid) begin
         item_ff <= item_in;
      end
   end

   assign dn_valid = valid_ff;
   assign dn_item  = item_ff;

endmodule

@@ design/booth_radix2_multiplier.sv @@
// Top level of the radix-2 Booth multiplier: width register, operand masking, stage chain.
// Depends on brm_pkg, the brm_*_if interfaces and brm_booth_stage.
//
//   channel   direction  carries                             transfer when
//   req_chan  in         multiplicand, multiplier            valid && ready
//   rsp_chan  out        product, nonzero_digits             valid && ready
//   csr_chan  in         operand_width                       valid && ready
//
// One operand pair enters per cycle while the request side is ready; a product passes
// through the masking stage and then one accumulation stage per eight Booth digits.
// Reset clears all stage valid bits and sets operand_width to 32.
// A stalled response holds its stage; upstream stages keep filling empty slots,
// so the request side stays ready until every stage holds an item.
// Width writes are always taken; change the width only while the pipeline is empty.
module booth_radix2_multiplier import brm_pkg::*; #(
   parameter int MAX_WIDTH = 32
) (
   input  logic     clock,
   input  logic     reset,
   brm_req_if.sink  req_chan,
   brm_rsp_if.source rsp_chan,
   brm_csr_if.sink  csr_chan
);

   localparam int NUM_GROUPS = (MAX_WIDTH + GROUP_DIGITS) / GROUP_DIGITS;
   localparam logic [CFG_W-1:0] MAX_W = CFG_W'(MAX_WIDTH);

   logic [CFG_W-1:0]     width_ff;
   logic [CFG_W-1:0]     eff_width;
   logic [OPERAND_W:0]   mask_wide;
   logic [OPERAND_W-1:0] op_mask;
   logic                 in_valid_ff;
   brm_item_type         in_item_ff;
   brm_item_type         in_item_in;

   logic                 stg_valid [0:NUM_GROUPS];
   logic                 stg_ready [0:NUM_GROUPS];
   brm_item_type         stg_item  [0:NUM_GROUPS];

   // width register
   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff <= WIDTH_RESET;
      end else if (csr_chan.valid) begin
         width_ff <= csr_chan.operand_width;
      end
   end

   // clamp width to 1..MAX_WIDTH and build the operand mask
   always_comb begin
      if (width_ff == '0) begin
         eff_width = CFG_W'(1);
      end else if (width_ff > MAX_W) begin
         eff_width = MAX_W;
      end else begin
         eff_width = width_ff;
      end
      mask_wide = ((OPERAND_W+1)'(1) << eff_width) - (OPERAND_W+1)'(1);
      op_mask   = mask_wide[OPERAND_W-1:0];
   end

   // masking stage: drop operand bits above the width, clear the accumulator
   always_comb begin
      in_item_in.multiplicand   = req_chan.multiplicand & op_mask;
      in_item_in.multiplier     = req_chan.multiplier & op_mask;
      in_item_in.product        = '0;
      in_item_in.nonzero_digits = '0;
   end

   assign req_chan.ready = !in_valid_ff || stg_ready[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_chan.ready) begin
         in_valid_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.ready && req_chan.valid) begin
         in_item_ff <= in_item_in;
      end
   end

   assign stg_valid[0] = in_valid_ff;
   assign stg_item[0]  = in_item_ff;

   // Booth accumulation chain, eight digits per stage
   for (genvar g = 0; g < NUM_GROUPS; g++) begin : g_stage
      brm_booth_stage #(
         .STAGE_IDX (g)
      ) u_stage (
         .clock    (clock),
         .reset    (reset),
         .up_valid (stg_valid[g]),
         .up_item  (stg_item[g]),
         .up_ready (stg_ready[g]),
         .dn_valid (stg_valid[g+1]),
         .dn_ready (stg_ready[g+1]),
         .dn_item  (stg_item[g+1])
      );
   end

   // response from the last stage
   assign stg_ready[NUM_GROUPS] = rsp_chan.ready;
   assign rsp_chan.valid          = stg_valid[NUM_GROUPS];
   assign rsp_chan.product        = stg_item[NUM_GROUPS].product;
   assign rsp_chan.nonzero_digits = stg_item[NUM_GROUPS].nonzero_digits;

endmodule

@@ design/brm_checker.sv @@
// Port-level checks for the Booth multiplier, bound to the top level.
// Depends on brm_pkg for field widths.
module brm_checker import brm_pkg::*; (
   input logic                 clock,
   input logic                 reset,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input logic [PRODUCT_W-1:0] rsp_product,
   input logic [COUNT_W-1:0]   rsp_nonzero_digits
);

   // reset empties the pipeline
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

   // no recoded digits only for a zero multiplier, hence a zero product
   a_zero_digits: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_nonzero_digits == '0) |-> rsp_product == '0)
      else $error("non-zero product with no Booth digits");

   // at most one digit per multiplier bit plus the top one
   a_digit_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_nonzero_digits <= COUNT_W'(OPERAND_W + 1))
      else $error("Booth digit count out of range");

   // a stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid && $stable(rsp_product)
                                    && $stable(rsp_nonzero_digits))
      else $error("stalled response changed");

endmodule

bind booth_radix2_multiplier brm_checker u_brm_checker (
   .clock              (clock),
   .reset              (reset),
   .rsp_valid          (rsp_chan.valid),
   .rsp_ready          (rsp_chan.ready),
   .rsp_product        (rsp_chan.product),
   .rsp_nonzero_digits (rsp_chan.nonzero_digits)
);
